FILE: rtl/hcd_pkg.sv
`default_nettype none

package hcd_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        finished;
        logic        status;
        logic [31:0] body_length;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_HEX   = 3'd0,
        CLS_SPACE = 3'd1,
        CLS_CR    = 3'd2,
        CLS_LF    = 3'd3,
        CLS_SEMI  = 3'd4,
        CLS_OTHER = 3'd5
    } t_cls;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
        t_cls       cls;
        logic [3:0] hex_val;
    } t_cls_item;

    typedef enum logic [5:0] {
        MODE_SIZE = 6'b000001,
        MODE_EXT  = 6'b000010,
        MODE_DATA = 6'b000100,
        MODE_GAP  = 6'b001000,
        MODE_DONE = 6'b010000,
        MODE_ERR  = 6'b100000
    } t_mode;

endpackage

`default_nettype wire

FILE: rtl/http_chunked_decoder.sv
// HTTP chunked body decoder.
// Input channel (i_in_valid / o_in_ready / i_in_data): one raw body byte per
// item, with a last flag on the final byte of the body.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// item per input item, in order: the decoded byte when data_valid is set, the
// finish flag and status on the last byte, and the running count of decoded
// bytes in body_length.
// Throughput: one item per cycle when the output side takes every result.
// Path: each item passes through the classify register, then the four-entry
// queue, whose head loads the output register.
// Reset: the decoder starts on a size line with all counts zero and the queue
// empty. After each last item it rearms for a new body by itself.
// Receiver stall: the output register holds its item; the queue fills behind
// it and o_in_ready drops once the queue and the classify register are full.
`default_nettype none

module http_chunked_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  hcd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output hcd_pkg::t_out_item  o_out_data
);
    import hcd_pkg::*;

    logic      push;
    logic      push_ready;
    t_cls_item push_data;
    logic      pop;
    logic      pop_valid;
    t_cls_item pop_data;

    hcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    hcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    hcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/hcd_front.sv
`default_nettype none

module hcd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  hcd_pkg::t_in_item   i_in_data,
    output logic                o_push,
    output hcd_pkg::t_cls_item  o_push_data,
    input  wire                 i_push_ready
);
    import hcd_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_cls_item r_item;
    t_cls_item n_item;

    always_comb begin
        n_item.in_byte = i_in_data.in_byte;
        n_item.last    = i_in_data.last;
        n_item.hex_val = 4'd0;
        n_item.cls     = CLS_OTHER;
        case (i_in_data.in_byte) inside
            [8'h30:8'h39]: begin
                n_item.cls     = CLS_HEX;
                n_item.hex_val = 4'(i_in_data.in_byte - 8'h30);
            end
            [8'h61:8'h66]: begin
                n_item.cls     = CLS_HEX;
                n_item.hex_val = 4'(i_in_data.in_byte - 8'h57);
            end
            [8'h41:8'h46]: begin
                n_item.cls     = CLS_HEX;
                n_item.hex_val = 4'(i_in_data.in_byte - 8'h37);
            end
            CH_SPACE: n_item.cls = CLS_SPACE;
            CH_CR:    n_item.cls = CLS_CR;
            CH_LF:    n_item.cls = CLS_LF;
            CH_SEMI:  n_item.cls = CLS_SEMI;
            default:  n_item.cls = CLS_OTHER;
        endcase
    end

    assign o_in_ready  = !r_valid || i_push_ready;
    assign o_push      = r_valid;
    assign o_push_data = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hcd_queue.sv
`default_nettype none

module hcd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  hcd_pkg::t_cls_item  i_push_data,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output hcd_pkg::t_cls_item  o_pop_data,
    input  wire                 i_pop
);
    import hcd_pkg::*;

    t_cls_item          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

FILE: rtl/hcd_back.sv
`default_nettype none

module hcd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_pop_valid,
    input  hcd_pkg::t_cls_item  i_pop_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output hcd_pkg::t_out_item  o_out_data
);
    import hcd_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [31:0] r_chunk;
    logic [31:0] n_chunk;
    logic        r_saw;
    logic        n_saw;
    logic [31:0] r_cnt;
    logic [31:0] n_cnt;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        run_size;
    logic [31:0] sz_chunk;
    logic        sz_saw;
    logic        good_end;

    assign o_pop       = i_pop_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_mode   = r_mode;
        n_chunk  = r_chunk;
        n_saw    = r_saw;
        n_cnt    = r_cnt;
        run_size = 1'b0;
        sz_chunk = r_chunk;
        sz_saw   = r_saw;
        n_out.data_valid = 1'b0;
        n_out.data_byte  = 8'd0;

        case (r_mode)
            MODE_SIZE: begin
                run_size = 1'b1;
            end
            MODE_EXT: begin
                if (i_pop_data.cls == CLS_LF) begin
                    n_mode = (r_chunk == '0) ? MODE_DONE : MODE_DATA;
                end
            end
            MODE_DATA: begin
                n_out.data_valid = 1'b1;
                n_out.data_byte  = i_pop_data.in_byte;
                n_cnt            = r_cnt + 32'd1;
                n_chunk          = r_chunk - 32'd1;
                if (n_chunk == '0) begin
                    n_mode = MODE_GAP;
                end
            end
            MODE_GAP: begin
                if (i_pop_data.cls != CLS_CR && i_pop_data.cls != CLS_LF) begin
                    run_size = 1'b1;
                    sz_chunk = '0;
                    sz_saw   = 1'b0;
                    n_mode   = MODE_SIZE;
                    n_chunk  = '0;
                    n_saw    = 1'b0;
                end
            end
            MODE_DONE: begin
            end
            default: begin
                n_mode = MODE_ERR;
            end
        endcase

        if (run_size) begin
            case (i_pop_data.cls)
                CLS_CR, CLS_SEMI: begin
                    n_mode = sz_saw ? MODE_EXT : MODE_ERR;
                end
                CLS_LF: begin
                    if (!sz_saw) begin
                        n_mode = MODE_ERR;
                    end else begin
                        n_mode = (sz_chunk == '0) ? MODE_DONE : MODE_DATA;
                    end
                end
                CLS_SPACE: begin
                end
                CLS_HEX: begin
                    if (|sz_chunk[31:28]) begin
                        n_mode = MODE_ERR;
                    end else begin
                        n_chunk = {sz_chunk[27:0], i_pop_data.hex_val};
                        n_saw   = 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_ERR;
                end
            endcase
        end

        good_end = (n_mode inside {MODE_DATA, MODE_GAP, MODE_DONE});
        n_out.finished    = i_pop_data.last;
        n_out.status      = i_pop_data.last && !good_end;
        n_out.body_length = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SIZE;
            r_chunk     <= '0;
            r_saw       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_pop_data.last) begin
                    r_mode  <= MODE_SIZE;
                    r_chunk <= '0;
                    r_saw   <= 1'b0;
                    r_cnt   <= '0;
                end else begin
                    r_mode  <= n_mode;
                    r_chunk <= n_chunk;
                    r_saw   <= n_saw;
                    r_cnt   <= n_cnt;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_status_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status |-> r_out.finished)
        else $error("error status without finish");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.data_valid |-> r_out.data_byte == 8'd0)
        else $error("data byte set without data valid");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_pop_data.last |=> r_mode == MODE_SIZE && r_cnt == '0 && !r_saw)
        else $error("decoder not rearmed after last item");

endmodule

`default_nettype wire

FILE: tb/sv/http_chunked_decoder_test.sv
`timescale 1ns / 100ps

module http_chunked_decoder_test;

    import hcd_pkg::*;

    localparam int unsigned ITEM_TARGET    = 1600;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned HOLD_BODY      = 10;
    localparam int unsigned PAUSE_BODY     = 25;

    localparam logic [31:0] SIZE_CEILING = 32'h0FFF_FFFF;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_UPPER_A   = 8'h41;
    localparam logic [7:0]  CH_LOWER_A   = 8'h61;

    class chunk_scoreboard;
        t_out_item   expected_q[$];
        t_mode       mode;
        logic [31:0] chunk_left;
        logic        saw_digit;
        logic [31:0] decoded_count;
        int unsigned err_count;

        function new();
            clear_body();
            err_count = 0;
        endfunction

        function void clear_body();
            mode          = MODE_SIZE;
            chunk_left    = '0;
            saw_digit     = 1'b0;
            decoded_count = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // 16 marks a byte that is not a hex digit
        function logic [4:0] digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
                return 5'(c - CH_ZERO);
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
                return 5'(c - CH_LOWER_A + 8'd10);
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
                return 5'(c - CH_UPPER_A + 8'd10);
            end
            return 5'd16;
        endfunction

        function void end_line();
            mode = (chunk_left == 32'd0) ? MODE_DONE : MODE_DATA;
        endfunction

        function void size_char(logic [7:0] c);
            logic [4:0] digit;
            if (c == CH_CR || c == CH_LF || c == CH_SEMI) begin
                if (!saw_digit) begin
                    mode = MODE_ERR;
                end else if (c == CH_LF) begin
                    end_line();
                end else begin
                    mode = MODE_EXT;
                end
            end else if (c != CH_SPACE) begin
                digit = digit_value(c);
                if (digit[4] || chunk_left > SIZE_CEILING) begin
                    mode = MODE_ERR;
                end else begin
                    chunk_left = {chunk_left[27:0], digit[3:0]};
                    saw_digit  = 1'b1;
                end
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            r = '0;
            case (mode)
                MODE_SIZE: size_char(it.in_byte);
                MODE_EXT: begin
                    if (it.in_byte == CH_LF) end_line();
                end
                MODE_DATA: begin
                    r.data_valid  = 1'b1;
                    r.data_byte   = it.in_byte;
                    decoded_count = decoded_count + 32'd1;
                    chunk_left    = chunk_left - 32'd1;
                    if (chunk_left == 32'd0) mode = MODE_GAP;
                end
                MODE_GAP: begin
                    if (it.in_byte != CH_CR && it.in_byte != CH_LF) begin
                        mode       = MODE_SIZE;
                        chunk_left = '0;
                        saw_digit  = 1'b0;
                        size_char(it.in_byte);
                    end
                end
                MODE_DONE: ;
                default: mode = MODE_ERR;
            endcase
            r.finished = it.last;
            if (it.last) begin
                r.status = (mode != MODE_DATA && mode != MODE_GAP && mode != MODE_DONE);
            end
            r.body_length = decoded_count;
            expected_q.push_back(r);
            if (it.last) clear_body();
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) $display("unexpected result item %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
                got.finished !== want.finished || got.status !== want.status ||
                got.body_length !== want.body_length) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("mismatch: expected dv=%0b byte=%h fin=%0b status=%0b len=%0d",
                             want.data_valid, want.data_byte, want.finished, want.status,
                             want.body_length);
                    $display("          got      dv=%0b byte=%h fin=%0b status=%0b len=%0d",
                             got.data_valid, got.data_byte, got.finished, got.status,
                             got.body_length);
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    chunk_scoreboard sb;
    logic [7:0]      body_q[$];
    int unsigned     burst_left = 0;
    int unsigned     items_sent = 0;
    bit              hold_req   = 1'b0;

    http_chunked_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_data);
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("http_chunked_decoder_test: errors");
        $finish;
    end

    initial begin : receiver
        int unsigned rx_cycle;
        int unsigned phase;
        rx_cycle = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            rx_cycle++;
            phase = (rx_cycle / 400) % 4;
            case (phase)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 99) < 75);
                2: i_out_ready <= ((rx_cycle % 7) < 4);
                default: i_out_ready <= ($urandom_range(0, 99) < 30);
            endcase
        end
    end

    function automatic void push_byte(logic [7:0] b);
        body_q.push_back(b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (($urandom_range(0, 1) == 0) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    function automatic void put_hex_digits(int unsigned n);
        int unsigned ndig;
        ndig = 1;
        while (ndig < 8 && (n >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--) begin
            push_byte(hex_char(4'((n >> (4 * i)) & 15)));
            if ($urandom_range(0, 9) == 0) push_byte(CH_SPACE);
        end
    endfunction

    function automatic void put_line_end();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
            1: push_byte(CH_LF);
            default: begin
                push_byte(($urandom_range(0, 1) == 0) ? CH_SEMI : CH_CR);
                repeat ($urandom_range(0, 5)) begin
                    b = 8'($urandom);
                    push_byte((b == CH_LF) ? CH_SEMI : b);
                end
                push_byte(CH_LF);
            end
        endcase
    endfunction

    function automatic void put_gap();
        case ($urandom_range(0, 2))
            0: begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
            1: ;
            default: begin
                repeat ($urandom_range(1, 4)) push_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
            end
        endcase
    endfunction

    function automatic void build_chunked_body();
        int unsigned size;
        repeat ($urandom_range(0, 4)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            put_hex_digits(size);
            put_line_end();
            repeat (size) push_byte(8'($urandom));
            put_gap();
        end
        put_hex_digits(0);
        put_line_end();
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
    endfunction

    task automatic send_body();
        t_in_item it;
        for (int i = 0; i < body_q.size(); i++) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
            end
            it.in_byte = body_q[i];
            it.last    = (i == body_q.size() - 1);
            i_in_valid <= 1'b1;
            i_in_data  <= it;
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
            burst_left--;
            items_sent++;
        end
        body_q.delete();
    endtask

    initial begin : stimulus
        int unsigned body_idx;
        int unsigned kind;
        int unsigned n;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_text("2");
        push_byte(CH_LF);
        push_byte(8'hFF);
        send_body();
        push_text("x");
        send_body();
        push_byte(CH_LF);
        send_body();
        push_text("FFFFFFFFF1");
        send_body();
        push_text("0");
        push_byte(CH_LF);
        push_text("x");
        send_body();
        push_text("1;");
        send_body();
        push_text("a");
        send_body();
        push_text("1 ");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'h00);
        push_byte(CH_CR);
        send_body();

        body_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (body_idx == HOLD_BODY) hold_req = 1'b1;
            if (body_idx == PAUSE_BODY) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (sb.pending() != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_chunked_body();
            end else if (kind < 80) begin
                build_chunked_body();
                body_q = body_q[0:$urandom_range(0, body_q.size() - 1)];
            end else if (kind < 87) begin
                build_chunked_body();
                body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom);
            end else if (kind < 94) begin
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
            end else begin
                n = $urandom;
                for (int i = 7; i >= 0; i--) push_byte(hex_char(4'((n >> (4 * i)) & 15)));
                if ($urandom_range(0, 1) == 0) push_byte(hex_char(4'($urandom)));
                put_line_end();
                repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
                if (body_q.size() == 0) push_byte(CH_LF);
            end
            send_body();
            body_idx++;
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("http_chunked_decoder_test: clean");
        end else begin
            $display("http_chunked_decoder_test: errors");
        end
        $finish;
    end

endmodule

FILE: http_chunked_decoder.f
rtl/hcd_pkg.sv
rtl/hcd_front.sv
rtl/hcd_queue.sv
rtl/hcd_back.sv
rtl/http_chunked_decoder.sv
tb/sv/http_chunked_decoder_test.sv
